### rtl/core/lsc_pkg.sv
// Shared types, constants and helper functions for the Laplacian sharpening core.
// Used by the top level, the input register and the window engine; depends on nothing.
`timescale 1ns / 1ps

package lsc_pkg;

    // Widest row the core supports, in output pixels.
    localparam int MAX_WIDTH = 1024;

    // Field and state widths.
    localparam int PIX_W   = 8;
    localparam int WIDTH_W = 11;
    localparam int CI_W    = $clog2(MAX_WIDTH);
    localparam int ACC_W   = 12;
    localparam int SUM_W   = ACC_W + 1;
    localparam int PHASE_W = 3;
    localparam int WGT_W   = 4;
    localparam int STORE_N = 6;
    localparam int COL_N   = 3;

    // Reset value of the row width register.
    localparam logic [WIDTH_W-1:0] ROW_WIDTH_RESET = WIDTH_W'(256);
    localparam logic [WIDTH_W-1:0] ROW_WIDTH_MIN   = WIDTH_W'(2);

    // Phase at which each kind of window completes.
    localparam logic [PHASE_W-1:0] PHASE_FIRST_DONE = PHASE_W'(5);
    localparam logic [PHASE_W-1:0] PHASE_NEXT_DONE  = PHASE_W'(2);

    // One staged input pixel.
    typedef struct packed {
        logic             valid;
        logic [PIX_W-1:0] pixel;
    } lsc_item_t;

    // Kernel weight for the pixel at a given phase of the first window of a row.
    // Phases 0..2 are the centre column, 3..5 the right column, top to bottom.
    function automatic logic signed [WGT_W-1:0] lsc_first_weight(
        input logic [PHASE_W-1:0] phase
    );
        logic signed [WGT_W-1:0] w;
        case (phase)
            3'd0:    w = -4'sd1;
            3'd1:    w = 4'sd5;
            3'd2:    w = -4'sd1;
            3'd4:    w = -4'sd1;
            default: w = 4'sd0;
        endcase
        return w;
    endfunction

    // Row width limited to the supported range.
    function automatic logic [WIDTH_W-1:0] lsc_eff_width(input logic [WIDTH_W-1:0] w);
        logic [WIDTH_W-1:0] r;
        r = w;
        if (w < ROW_WIDTH_MIN)
        begin
            r = ROW_WIDTH_MIN;
        end
        else if (int'(w) > MAX_WIDTH)
        begin
            r = WIDTH_W'(MAX_WIDTH);
        end
        return r;
    endfunction

    // Clamp a signed window sum to the pixel range.
    function automatic logic [PIX_W-1:0] lsc_clamp(input logic signed [SUM_W-1:0] s);
        logic [PIX_W-1:0] r;
        if (s < 0)
        begin
            r = '0;
        end
        else if (s > SUM_W'(255))
        begin
            r = {PIX_W{1'b1}};
        end
        else
        begin
            r = s[PIX_W-1:0];
        end
        return r;
    endfunction

endpackage

### rtl/core/laplacian_sharpen_column_stream_core.sv
// Top level of the column-fed 3x3 Laplacian sharpening core: ports and row width register.
// Depends on lsc_pkg, lsc_in_stage and lsc_engine.
`timescale 1ns / 1ps

// Pixels arrive three per column, top to bottom, one pixel per transaction; the core
// accepts a pixel in every cycle while its output is taken. The first output of a row
// completes after six pixels, every later one after three. Each pixel is first held in
// the input register, and as it moves on from there the window engine updates its
// column store and running sum and, once the pixel completes a window, also
// loads the result register. A result waiting on the output holds the next pixel in the
// input register, so the input closes once that register is full as well. row_width
// (2..1024, values outside act as the nearest bound) sets the outputs per row and should
// be written only while the core is idle; the column store is cleared at each row end.
module laplacian_sharpen_column_stream_core
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration: row_width, bits 10:0.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [10:0] cfg_data,
    // Input pixels.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] pixel
    // Sharpened pixels.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [7:0] sharpened
);

    logic [lsc_pkg::WIDTH_W-1:0] row_width_reg;
    logic [lsc_pkg::WIDTH_W-1:0] row_width_next;
    lsc_pkg::lsc_item_t          item;
    logic                        advance;

    // Row width register, written on every configuration transaction.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        row_width_next = row_width_reg;
        if (cfg_valid && cfg_ready)
        begin
            row_width_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg <= lsc_pkg::ROW_WIDTH_RESET;
        end
        else
        begin
            row_width_reg <= row_width_next;
        end
    end

    // Input register.
    lsc_in_stage u_in_stage
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_pixel (s_axis_tdata),
        .advance  (advance),
        .item     (item)
    );

    // Window engine and result register.
    lsc_engine u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .row_width (row_width_reg),
        .advance   (advance),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_pixel (m_axis_tdata)
    );

endmodule

### rtl/core/lsc_in_stage.sv
// Input register of the sharpening core: holds one accepted pixel until the engine takes it.
// Depends on lsc_pkg.
`timescale 1ns / 1ps

module lsc_in_stage
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [lsc_pkg::PIX_W-1:0] in_pixel,
    input  logic                     advance,
    output lsc_pkg::lsc_item_t       item
);

    logic                      valid_reg;
    logic                      valid_next;
    logic [lsc_pkg::PIX_W-1:0] pixel_reg;
    logic [lsc_pkg::PIX_W-1:0] pixel_next;

    // The register frees up in the same cycle that the engine takes its pixel.
    assign in_ready = !valid_reg || advance;

    // Load on a new transaction, empty when the pixel moves on.
    always_comb
    begin
        valid_next = valid_reg;
        pixel_next = pixel_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
            pixel_next = in_pixel;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pixel_reg <= pixel_next;
    end

    assign item.valid = valid_reg;
    assign item.pixel = pixel_reg;

endmodule

### rtl/core/lsc_engine.sv
// Window engine of the sharpening core: column store, running sum, clamp and result register.
// Depends on lsc_pkg.
`timescale 1ns / 1ps

module lsc_engine
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  lsc_pkg::lsc_item_t           item,
    input  logic [lsc_pkg::WIDTH_W-1:0]  row_width,
    output logic                         advance,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [lsc_pkg::PIX_W-1:0]    out_pixel
);

    localparam int PIX_W   = lsc_pkg::PIX_W;
    localparam int CI_W    = lsc_pkg::CI_W;
    localparam int ACC_W   = lsc_pkg::ACC_W;
    localparam int SUM_W   = lsc_pkg::SUM_W;
    localparam int PHASE_W = lsc_pkg::PHASE_W;
    localparam int STORE_N = lsc_pkg::STORE_N;
    localparam int COL_N   = lsc_pkg::COL_N;

    logic [PIX_W-1:0]          store_reg [STORE_N];
    logic [PIX_W-1:0]          store_next [STORE_N];
    logic [PIX_W-1:0]          store_wr [STORE_N];
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   acc_next;
    logic [PHASE_W-1:0]        phase_reg;
    logic [PHASE_W-1:0]        phase_next;
    logic [CI_W-1:0]           ci_reg;
    logic [CI_W-1:0]           ci_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [PIX_W-1:0]          out_pixel_reg;
    logic [PIX_W-1:0]          out_pixel_next;

    logic [lsc_pkg::WIDTH_W-1:0] eff_width;
    logic signed [SUM_W-1:0]   pix_s;
    logic signed [SUM_W-1:0]   carry_sum;
    logic signed [SUM_W-1:0]   term;
    logic signed [SUM_W-1:0]   acc_sum;
    logic                      done;
    logic                      row_end;

    // A pixel moves on when the result register is empty or being drained.
    assign advance   = item.valid && (!out_valid_reg || out_ready);
    assign eff_width = lsc_pkg::lsc_eff_width(row_width);
    assign pix_s     = $signed(SUM_W'(item.pixel));

    // Contribution of the stored columns to a later window: -up(left) and the centre column.
    assign carry_sum = SUM_W'(5) * $signed(SUM_W'(store_reg[4]))
                     - $signed(SUM_W'(store_reg[1]))
                     - $signed(SUM_W'(store_reg[3]))
                     - $signed(SUM_W'(store_reg[5]));

    assign row_end = (int'(ci_reg) >= int'(eff_width) - 1);

    // Accumulate the pixel, store it and step the window position.
    always_comb
    begin
        term           = '0;
        done           = 1'b0;
        store_wr       = store_reg;
        store_next     = store_reg;
        phase_next     = phase_reg;
        ci_next        = ci_reg;
        acc_sum        = SUM_W'(acc_reg);
        acc_next       = acc_reg;
        out_pixel_next = out_pixel_reg;
        out_valid_next = out_valid_reg;

        if (ci_reg == '0)
        begin
            if (phase_reg < PHASE_W'(STORE_N))
            begin
                term = pix_s * SUM_W'(lsc_pkg::lsc_first_weight(phase_reg));
                for (int k = 0; k < STORE_N; k++)
                begin
                    if (phase_reg == PHASE_W'(k))
                    begin
                        store_wr[k] = item.pixel;
                    end
                end
                done = (phase_reg == lsc_pkg::PHASE_FIRST_DONE);
            end
        end
        else if (phase_reg < PHASE_W'(COL_N))
        begin
            if (phase_reg == '0)
            begin
                term = carry_sum;
            end
            else if (phase_reg == PHASE_W'(1))
            begin
                term = -pix_s;
            end
            for (int k = 0; k < COL_N; k++)
            begin
                if (phase_reg == PHASE_W'(k))
                begin
                    store_wr[k] = item.pixel;
                end
            end
            done = (phase_reg == lsc_pkg::PHASE_NEXT_DONE);
        end

        acc_sum = SUM_W'(acc_reg) + term;

        if (advance)
        begin
            // Running sum, cleared once a window completes.
            if (done)
            begin
                acc_next = '0;
            end
            else
            begin
                acc_next = acc_sum[ACC_W-1:0];
            end

            // Window position and column store.
            store_next = store_wr;
            if (ci_reg != '0 && phase_reg == lsc_pkg::PHASE_NEXT_DONE)
            begin
                phase_next = '0;
                if (row_end)
                begin
                    ci_next = '0;
                    for (int k = 0; k < STORE_N; k++)
                    begin
                        store_next[k] = '0;
                    end
                end
                else
                begin
                    ci_next = ci_reg + CI_W'(1);
                    for (int k = 0; k < COL_N; k++)
                    begin
                        store_next[k]         = store_wr[COL_N + k];
                        store_next[COL_N + k] = store_wr[k];
                    end
                end
            end
            else if (ci_reg == '0 && phase_reg == lsc_pkg::PHASE_FIRST_DONE)
            begin
                ci_next    = CI_W'(1);
                phase_next = '0;
            end
            else
            begin
                phase_next = phase_reg + PHASE_W'(1);
            end

            // Result register.
            out_valid_next = done;
            if (done)
            begin
                out_pixel_next = lsc_pkg::lsc_clamp(acc_sum);
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < STORE_N; k++)
            begin
                store_reg[k] <= '0;
            end
            acc_reg       <= '0;
            phase_reg     <= '0;
            ci_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            store_reg     <= store_next;
            acc_reg       <= acc_next;
            phase_reg     <= phase_next;
            ci_reg        <= ci_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_pixel_reg <= out_pixel_next;
    end

    assign out_valid = out_valid_reg;
    assign out_pixel = out_pixel_reg;

endmodule

### rtl/core/lsc_checker.sv
// Port-level assertions for the sharpening core, attached to the top level by bind.
// Depends on laplacian_sharpen_column_stream_core.
`timescale 1ns / 1ps

module lsc_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // A stalled result keeps its value.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // With no result pending the input side is always open.
    a_in_open: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");

    // With both registers full and the output still stalled, input stays closed.
    a_in_closed: assert property (@(posedge clk) disable iff (!rst_n)
        $past(m_axis_tvalid && !m_axis_tready && !s_axis_tready) && !m_axis_tready
        |-> !s_axis_tready)
        else $error("input opened while pipeline full and stalled");

endmodule

bind laplacian_sharpen_column_stream_core lsc_checker u_lsc_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

### test/tb_top.sv
// Self-checking testbench for the column-fed 3x3 Laplacian sharpening core.
// Drives pixel and row width transactions, predicts every sharpened pixel and checks it.
// Depends on lsc_pkg and laplacian_sharpen_column_stream_core.
`timescale 1ns / 1ps

// Predicts the sharpened pixels from the accepted input pixels and checks the outputs.
class sharpen_scoreboard;
    logic [lsc_pkg::WIDTH_W-1:0]      row_width;
    logic [lsc_pkg::PIX_W-1:0]        column_store [lsc_pkg::STORE_N];
    logic signed [lsc_pkg::ACC_W-1:0] window_sum;
    logic [lsc_pkg::PHASE_W-1:0]      window_phase;
    logic [lsc_pkg::CI_W-1:0]         out_column;
    logic [lsc_pkg::PIX_W-1:0]        expected_sharpened [$];
    int                               errors;

    function new();
        row_width = lsc_pkg::ROW_WIDTH_RESET;
        foreach (column_store[i])
        begin
            column_store[i] = '0;
        end
        window_sum   = '0;
        window_phase = '0;
        out_column   = '0;
        errors       = 0;
    endfunction

    // Kernel weight by column (0 left, 1 centre, 2 right) and row (0 top).
    function int kernel_weight(int col, int row);
        if (col == 1)
        begin
            return (row == 1) ? 5 : -1;
        end
        return (row == 1) ? -1 : 0;
    endfunction

    function int outstanding();
        return expected_sharpened.size();
    endfunction

    // Advance the prediction by one accepted pixel.
    function void note_pixel(logic [lsc_pkg::PIX_W-1:0] pix);
        int                        limit;
        int                        sum;
        bit                        done;
        logic [lsc_pkg::PIX_W-1:0] held;
        limit = row_width;
        if (limit < 2)
        begin
            limit = 2;
        end
        else if (limit > lsc_pkg::MAX_WIDTH)
        begin
            limit = lsc_pkg::MAX_WIDTH;
        end
        done = 1'b0;
        sum  = window_sum;

        // The first window of a row takes the centre and right columns; the left is zero.
        if (out_column == 0)
        begin
            if (window_phase < 6)
            begin
                sum += int'(pix) * kernel_weight(1 + window_phase / 3, window_phase % 3);
                column_store[window_phase] = pix;
                done = (window_phase == 5);
            end
        end
        else if (window_phase < 3)
        begin
            // Later windows pull the left and centre columns from the store.
            if (window_phase == 0)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    sum += int'(column_store[i]) * kernel_weight(0, i);
                    sum += int'(column_store[3 + i]) * kernel_weight(1, i);
                end
            end
            sum += int'(pix) * kernel_weight(2, window_phase);
            column_store[window_phase] = pix;
            done = (window_phase == 2);
        end
        window_sum = sum[lsc_pkg::ACC_W-1:0];

        // A completed window yields one clamped pixel.
        if (done)
        begin
            if (window_sum < 0)
            begin
                expected_sharpened.push_back('0);
            end
            else if (window_sum > 255)
            begin
                expected_sharpened.push_back(8'hFF);
            end
            else
            begin
                expected_sharpened.push_back(window_sum[lsc_pkg::PIX_W-1:0]);
            end
            window_sum = '0;
        end

        // Step through the row; the store is cleared when the row ends.
        if (out_column != 0 && window_phase == 2)
        begin
            if (out_column >= limit - 1)
            begin
                foreach (column_store[i])
                begin
                    column_store[i] = '0;
                end
                out_column = '0;
            end
            else
            begin
                for (int i = 0; i < 3; i++)
                begin
                    held                = column_store[i];
                    column_store[i]     = column_store[3 + i];
                    column_store[3 + i] = held;
                end
                out_column = out_column + 1'b1;
            end
            window_phase = '0;
        end
        else if (out_column == 0 && window_phase == 5)
        begin
            out_column   = lsc_pkg::CI_W'(1);
            window_phase = '0;
        end
        else
        begin
            window_phase = window_phase + 1'b1;
        end
    endfunction

    // Compare one output transaction with the oldest predicted pixel.
    function void check_result(logic [lsc_pkg::PIX_W-1:0] actual);
        logic [lsc_pkg::PIX_W-1:0] predicted;
        if (expected_sharpened.size() == 0)
        begin
            $display("%0t: unexpected sharpened pixel, expected none, actual %0d",
                     $time, actual);
            errors++;
        end
        else
        begin
            predicted = expected_sharpened.pop_front();
            if (predicted !== actual)
            begin
                $display("%0t: sharpened pixel mismatch, expected %0d, actual %0d",
                         $time, predicted, actual);
                errors++;
            end
        end
    endfunction
endclass

module tb_top;

    localparam int LIMIT_CYCLES    = 400000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 6;
    localparam int PHASE_COUNT     = 12;
    // A negative width selects a random small width for that phase.
    localparam int PHASE_WIDTH [PHASE_COUNT] =
        '{0, 1, -1, 2047, 1024, 2, 1025, -1, 3, -1, 5, -1};
    localparam int PHASE_ITEMS [PHASE_COUNT] =
        '{50, 50, 100, 120, 150, 60, 80, 70, 90, 70, 70, 60};
    // Three short rows at width two: two that clamp high, and one with sums inside the range.
    localparam logic [7:0] DIRECTED_PIXELS [27] = '{
        8'd0,   8'd255, 8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 8'd255, 8'd255,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd10,  8'd20,  8'd30,
        8'd10,  8'd20,  8'd30,  8'd40,  8'd50,  8'd60,  8'd1,   8'd2,   8'd3
    };

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [10:0] cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;

    sharpen_scoreboard sb;
    int                traffic_mode;
    bit                stall_request;
    int                cycle_count = 0;

    laplacian_sharpen_column_stream_core dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 100 MHz clock.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Abort a run that hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Note accepted pixels and check accepted results on the same edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                sb.note_pixel(s_axis_tdata);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                sb.check_result(m_axis_tdata);
            end
        end
    end

    // Output side: random stalls by traffic mode, plus one long hold-off on request.
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_request)
            begin
                stall_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else if (traffic_mode == 2)
            begin
                m_axis_tready <= ($urandom_range(0, 99) >= 86);
            end
            else if (traffic_mode == 3)
            begin
                m_axis_tready <= ($urandom_range(0, 99) >= 30);
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Pixels favor the extremes now and then so that both clamps are reached.
    function automatic logic [7:0] random_pixel();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Offer one pixel, with random gaps first, and wait for its transaction.
    task automatic send_pixel(input logic [7:0] pix);
        int idle_pct;
        idle_pct = (traffic_mode == 1) ? 86 : (traffic_mode == 3) ? 30 : 0;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        do
        begin
            @(posedge clk);
        end
        while (!(s_axis_tvalid && s_axis_tready));
    endtask

    // Wait until every predicted pixel has come out and the pipeline has settled.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the row width register; only called while the core is idle.
    task automatic write_width(input logic [10:0] width);
        cfg_valid <= 1'b1;
        cfg_data  <= width;
        do
        begin
            @(posedge clk);
        end
        while (!(cfg_valid && cfg_ready));
        sb.row_width = width;
        cfg_valid <= 1'b0;
    endtask

    // Stimulus: directed rows, then random phases with changing width and traffic.
    initial
    begin
        int          n;
        logic [10:0] width;
        sb            = new();
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        traffic_mode  = 0;
        stall_request = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_width(11'd2);
        foreach (DIRECTED_PIXELS[i])
        begin
            send_pixel(DIRECTED_PIXELS[i]);
        end
        drain();

        // Phases often end mid-row, so a lowered width can end a row early.
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            traffic_mode = p % 4;
            if (PHASE_WIDTH[p] < 0)
            begin
                width = 11'($urandom_range(3, 40));
            end
            else
            begin
                width = 11'(PHASE_WIDTH[p]);
            end
            write_width(width);
            if (p == 4)
            begin
                stall_request = 1'b1;
            end
            n = PHASE_ITEMS[p] + $urandom_range(0, 5);
            repeat (n) send_pixel(random_pixel());
            drain();
        end

        if (sb.errors == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
